// ===== sv/gohm_pkg.sv =====
// Package for the grid occurrence heat map: operation codes, register indexes
// and the job record passed from front to back. No dependencies.
package gohm_pkg;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] REG_COLUMNS = 3'd0;
  localparam logic [2:0] REG_ROWS    = 3'd1;
  localparam logic [2:0] REG_CWIDTH  = 3'd2;
  localparam logic [2:0] REG_CHEIGHT = 3'd3;
  localparam logic [2:0] REG_TPOINT  = 3'd4;

  localparam logic [3:0] TP_NW = 4'd1, TP_N = 4'd2, TP_NE = 4'd3, TP_E = 4'd4;
  localparam logic [3:0] TP_SE = 4'd5, TP_S = 4'd6, TP_SW = 4'd7, TP_W = 4'd8;

  localparam int PALETTE_STEPS = 10;

  typedef struct packed {
    op_t         op;
    logic [3:0]  row;
    logic [3:0]  col;
  } job_t;

  typedef struct packed {
    logic [4:0]  cols;
    logic [4:0]  rows;
    logic [13:0] cw;
    logic [13:0] ch;
  } geom_t;

endpackage

// ===== sv/gohm_front.sv =====
// Front part: takes commands, finds the grid cell of a record by iterative
// division, clamps read cells, and pushes jobs to the queue. Uses gohm_pkg.
module gohm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_operation,
  input  logic [12:0]         in_box_left,
  input  logic [12:0]         in_box_top,
  input  logic [12:0]         in_box_width,
  input  logic [12:0]         in_box_height,
  input  logic [3:0]          in_read_row,
  input  logic [3:0]          in_read_column,
  input  gohm_pkg::geom_t     geom,
  input  logic [3:0]          test_point,
  input  logic                q_full,
  output logic                q_push,
  output gohm_pkg::job_t      q_data
);
  import gohm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_PUSH} state_t;
  state_t      state_r;
  logic [13:0] xq_r, yq_r, xr_r, yr_r, xn_r, yn_r;
  logic [3:0]  cnt_r;
  job_t        job_r;

  logic [13:0] hw, hh, dx, dy;
  logic [13:0] x, y;
  always_comb begin
    hw = ({1'b0, in_box_width} + 14'd1) >> 1;
    hh = ({1'b0, in_box_height} + 14'd1) >> 1;
    case (test_point)
      TP_NW: begin dx = '0; dy = '0; end
      TP_N: begin dx = hw; dy = '0; end
      TP_NE: begin dx = {1'b0, in_box_width}; dy = '0; end
      TP_E: begin dx = {1'b0, in_box_width}; dy = hh; end
      TP_SE: begin dx = {1'b0, in_box_width}; dy = {1'b0, in_box_height}; end
      TP_S: begin dx = hw; dy = {1'b0, in_box_height}; end
      TP_SW: begin dx = '0; dy = {1'b0, in_box_height}; end
      TP_W: begin dx = '0; dy = hh; end
      default: begin dx = hw; dy = hh; end
    endcase
    x = {1'b0, in_box_left} + dx;
    y = {1'b0, in_box_top} + dy;
  end

  logic [13:0] cw, ch;
  logic [4:0]  cols, rows;
  assign cw = (geom.cw == '0) ? 14'd1 : geom.cw;
  assign ch = (geom.ch == '0) ? 14'd1 : geom.ch;
  assign cols = (geom.cols == '0) ? 5'd1 : (geom.cols > 5'd16 ? 5'd16 : geom.cols);
  assign rows = (geom.rows == '0) ? 5'd1 : (geom.rows > 5'd16 ? 5'd16 : geom.rows);

  logic [14:0] xt, yt;
  logic [4:0]  lastc, lastr;
  logic        fix_pend;
  assign xt = {xr_r, xn_r[13]};
  assign yt = {yr_r, yn_r[13]};
  assign lastc = cols - 5'd1;
  assign lastr = rows - 5'd1;
  assign fix_pend = (job_r.op == OP_RECORD) && (cnt_r == 4'd14);

  function automatic logic [3:0] clamp4(input logic [13:0] v, input logic [4:0] last);
    clamp4 = (v > {9'd0, last}) ? last[3:0] : v[3:0];
  endfunction

  assign busy = (state_r != S_IDLE);
  assign q_push = (state_r == S_PUSH) && !q_full && !fix_pend;
  assign q_data = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (start) begin
          job_r.op <= op_t'(in_operation);
          if (op_t'(in_operation) == OP_RECORD) begin
            job_r.row <= '0;
            job_r.col <= '0;
            xn_r <= x; yn_r <= y; xr_r <= '0; yr_r <= '0;
            xq_r <= '0; yq_r <= '0; cnt_r <= '0;
            state_r <= S_DIV;
          end else begin
            if (op_t'(in_operation) == OP_READ) begin
              job_r.row <= clamp4({10'd0, in_read_row}, lastr);
              job_r.col <= clamp4({10'd0, in_read_column}, lastc);
            end else begin
              job_r.row <= '0;
              job_r.col <= '0;
            end
            state_r <= S_PUSH;
          end
        end
        S_DIV: begin
          xn_r <= xn_r << 1;
          yn_r <= yn_r << 1;
          if (xt >= {1'b0, cw}) begin
            xr_r <= 14'(xt - {1'b0, cw}); xq_r <= {xq_r[12:0], 1'b1};
          end else begin
            xr_r <= xt[13:0]; xq_r <= {xq_r[12:0], 1'b0};
          end
          if (yt >= {1'b0, ch}) begin
            yr_r <= 14'(yt - {1'b0, ch}); yq_r <= {yq_r[12:0], 1'b1};
          end else begin
            yr_r <= yt[13:0]; yq_r <= {yq_r[12:0], 1'b0};
          end
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd13) state_r <= S_PUSH;
        end
        S_PUSH: if (!q_full && !fix_pend) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
      if (state_r == S_PUSH && fix_pend) begin
        job_r.row <= clamp4(yq_r, lastr);
        job_r.col <= clamp4(xq_r, lastc);
        cnt_r <= 4'd15;
      end
    end
  end

  // keep the push off until the cell has been latched
  // (record jobs fix row/col while in PUSH, before the push goes out)
endmodule

// ===== sv/gohm_back.sv =====
// Back part: carries out jobs on the count memory, tracks the peak, clears,
// and forms the palette index by a serial loop. Uses gohm_pkg.
module gohm_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  gohm_pkg::job_t        q_data,
  output logic                  q_pop,
  input  gohm_pkg::geom_t       geom,
  output logic                  idle,
  output logic                  out_strobe,
  output logic [3:0]            out_cell_row,
  output logic [3:0]            out_cell_column,
  output logic [31:0]           out_cell_count,
  output logic [31:0]           out_peak_count,
  output logic [3:0]            out_palette_index,
  output logic                  out_occupied,
  output logic [16:0]           out_rect_x,
  output logic [16:0]           out_rect_y
);
  import gohm_pkg::*;

  typedef enum logic [2:0] {B_INIT, B_IDLE, B_RD, B_WR, B_PAL, B_OUT, B_CLR} state_t;
  state_t                  state_r;
  logic [COUNT_BITS-1:0]   mem [256];
  logic [COUNT_BITS-1:0]   rd_r, cnt_r, peak_r, rem_r;
  logic [7:0]              addr_r;
  logic [3:0]              q_r, step_r;
  job_t                    job_r;
  logic [16:0]             rx_r, ry_r;

  localparam logic [COUNT_BITS-1:0] LIM = '1;
  logic [COUNT_BITS-1:0] inc, rem_add;
  assign inc = (rd_r == LIM) ? rd_r : rd_r + 1'b1;
  assign rem_add = cnt_r + rem_r;

  logic [13:0] cw, ch;
  assign cw = (geom.cw == '0) ? 14'd1 : geom.cw;
  assign ch = (geom.ch == '0) ? 14'd1 : geom.ch;

  assign idle = (state_r == B_IDLE);
  assign q_pop = idle && q_valid;

  always_ff @(posedge clk) begin
    if (state_r == B_WR && job_r.op == OP_RECORD) mem[addr_r] <= inc;
    if (state_r == B_CLR || state_r == B_INIT) mem[addr_r] <= '0;
    rd_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      addr_r <= '0;
      peak_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state_r)
        B_INIT, B_CLR: begin
          addr_r <= addr_r + 8'd1;
          if (addr_r == 8'hFF) begin
            if (state_r == B_CLR) begin
              out_strobe <= 1'b1;
              out_cell_row <= '0; out_cell_column <= '0; out_cell_count <= '0;
              out_peak_count <= '0; out_palette_index <= '0; out_occupied <= 1'b0;
              out_rect_x <= '0; out_rect_y <= '0;
            end
            state_r <= B_IDLE;
          end
        end
        B_IDLE: if (q_valid) begin
          job_r <= q_data;
          addr_r <= (q_data.op == OP_CLEAR) ? 8'd0 : {q_data.row, q_data.col};
          rx_r <= 17'({3'd0, cw} * q_data.col);
          ry_r <= 17'({3'd0, ch} * q_data.row);
          case (q_data.op)
            OP_RECORD, OP_READ: state_r <= B_RD;
            OP_CLEAR: begin peak_r <= '0; state_r <= B_CLR; end
            default: begin
              out_strobe <= 1'b1;
              out_cell_row <= '0; out_cell_column <= '0; out_cell_count <= '0;
              out_peak_count <= '0; out_palette_index <= '0; out_occupied <= 1'b0;
              out_rect_x <= '0; out_rect_y <= '0;
            end
          endcase
        end
        B_RD: state_r <= B_WR;
        B_WR: begin
          if (job_r.op == OP_RECORD) begin
            cnt_r <= inc;
            if (inc > peak_r) peak_r <= inc;
          end else begin
            cnt_r <= rd_r;
          end
          rem_r <= '0; q_r <= '0; step_r <= '0;
          state_r <= B_PAL;
        end
        B_PAL: begin
          if (step_r < 4'(PALETTE_STEPS)) begin
            if (cnt_r >= peak_r - rem_r) begin
              rem_r <= cnt_r - (peak_r - rem_r); q_r <= q_r + 4'd1;
            end else begin
              rem_r <= rem_add;
            end
            step_r <= step_r + 4'd1;
          end else begin
            if (peak_r != '0 && rem_r >= peak_r - rem_r && q_r < 4'(PALETTE_STEPS))
              q_r <= q_r + 4'd1;
            state_r <= B_OUT;
          end
        end
        B_OUT: begin
          out_strobe <= 1'b1;
          out_cell_row <= job_r.row; out_cell_column <= job_r.col;
          out_cell_count <= 32'(cnt_r); out_peak_count <= 32'(peak_r);
          out_palette_index <= (peak_r == '0) ? 4'd0 : q_r;
          out_occupied <= (cnt_r != '0);
          out_rect_x <= rx_r; out_rect_y <= ry_r;
          state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT) |=> out_strobe);
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == B_IDLE)) else $error("pop outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT) |-> (cnt_r <= peak_r)) else $error("count above peak");
endmodule

// ===== sv/gohm_queue.sv =====
// Two-entry job queue between front and back. Uses gohm_pkg.
module gohm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gohm_pkg::job_t din,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output gohm_pkg::job_t dout
);
  import gohm_pkg::*;
  job_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] n_r;
  assign full = (n_r == 2'd2);
  assign valid = (n_r != 2'd0);
  assign dout = buf_r[rp_r];
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= din;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; n_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      n_r <= n_r + 2'(push) - 2'(pop);
    end
  end
  assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(pop && !valid))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n) n_r != 2'd3)
    else $error("bad fill");
endmodule

// ===== sv/grid_occurrence_heat_map_core.sv =====
// Grid occurrence heat map core: front decode/divide, job queue, back memory.
// One item at a time; busy stays high from acceptance until the result strobe.
// After reset a clearing pass over all 256 memory words runs; start is held off by busy meanwhile.
// Results appear on out_strobe for one cycle; the receiver cannot stall.
module grid_occurrence_heat_map_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [12:0] in_box_left,
  input  logic [12:0] in_box_top,
  input  logic [12:0] in_box_width,
  input  logic [12:0] in_box_height,
  input  logic [3:0]  in_read_row,
  input  logic [3:0]  in_read_column,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [13:0] cfg_data,
  output logic        out_strobe,
  output logic [3:0]  out_cell_row,
  output logic [3:0]  out_cell_column,
  output logic [31:0] out_cell_count,
  output logic [31:0] out_peak_count,
  output logic [3:0]  out_palette_index,
  output logic        out_occupied,
  output logic [16:0] out_rect_x,
  output logic [16:0] out_rect_y
);
  import gohm_pkg::*;

  geom_t      geom_r;
  logic [3:0] tp_r;
  logic       fbusy, q_full, q_push, q_valid, q_pop, b_idle, pend_r;
  job_t       q_in, q_out;

  assign cfg_ready = 1'b1;
  assign busy = fbusy || q_valid || !b_idle || pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= '{cols: 5'd16, rows: 5'd16, cw: 14'd120, ch: 14'd68};
      tp_r <= '0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= q_pop;
      if (cfg_valid) begin
        case (cfg_index)
          REG_COLUMNS: geom_r.cols <= cfg_data[4:0];
          REG_ROWS:    geom_r.rows <= cfg_data[4:0];
          REG_CWIDTH:  geom_r.cw <= cfg_data;
          REG_CHEIGHT: geom_r.ch <= cfg_data;
          REG_TPOINT:  tp_r <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  gohm_front u_front (
    .clk, .rst_n, .start(start && !busy), .busy(fbusy),
    .in_operation, .in_box_left, .in_box_top, .in_box_width, .in_box_height,
    .in_read_row, .in_read_column, .geom(geom_r), .test_point(tp_r),
    .q_full, .q_push, .q_data(q_in)
  );

  gohm_queue u_queue (
    .clk, .rst_n, .push(q_push), .din(q_in), .pop(q_pop), .full(q_full),
    .valid(q_valid), .dout(q_out)
  );

  gohm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_data(q_out), .q_pop, .geom(geom_r), .idle(b_idle),
    .out_strobe, .out_cell_row, .out_cell_column, .out_cell_count, .out_peak_count,
    .out_palette_index, .out_occupied, .out_rect_x, .out_rect_y
  );
endmodule
